// ===== src/mid_pkg.sv =====
// Shared types and constants of the multi-input debouncer.
// Used by mid_chan, multi_input_debouncer_top, mid_level_checker and the testbench; depends on nothing.
`default_nettype none

package mid_pkg;

	localparam int CHANNELS = 10;   // debounced channels, 1 to 32
	localparam int FIELD_W  = 10;   // width of raw_pins and stable_levels_out
	localparam int CNT_W    = 8;    // settle counter and settle time width
	localparam int MASK_W   = 10;   // normally-open mask register width
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [CNT_W-1:0] SETTLE_RESET = CNT_W'(4);

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_TICK   = 1'b1
	} func_t;

	typedef enum logic {
		REG_SETTLE_TIME = 1'b0,
		REG_NO_MASK     = 1'b1
	} reg_idx_t;

	// per-item control broadcast to every channel
	typedef struct packed {
		logic             upd;
		logic             tick;
		logic [CNT_W-1:0] settle_time;
	} chan_ctl_t;

	// channel level now and after the item in flight
	typedef struct packed {
		logic stable_q;
		logic stable_d;
	} chan_stat_t;

endpackage

`default_nettype wire

// ===== src/mid_chan.sv =====
// One debounce channel: sampled level, settle counter and stable level.
// Depends on mid_pkg for the control and status structs.
`default_nettype none

module mid_chan (
	input  wire                       clk,
	input  wire                       arst_n,
	input  mid_pkg::chan_ctl_t        ctl,
	input  wire                       raw,
	input  wire                       no_bit,
	output mid_pkg::chan_stat_t       stat
);

	logic                      sampled_q;
	logic                      stable_q;
	logic [mid_pkg::CNT_W-1:0] cnt_q;

	logic                      changed;
	logic [mid_pkg::CNT_W-1:0] cnt_smp;
	logic                      settled;
	logic                      stable_d;
	logic                      cnt_adv;

	assign changed = raw != sampled_q;
	assign cnt_smp = changed ? '0 : cnt_q;
	assign settled = cnt_smp >= ctl.settle_time;
	// counter stops past the settle time and at its top value
	assign cnt_adv = (cnt_q <= ctl.settle_time) && (cnt_q != '1);

	always_comb begin
		stable_d = stable_q;
		if (ctl.upd && !ctl.tick && settled) begin
			stable_d = raw ^ no_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampled_q <= 1'b0;
			stable_q  <= 1'b0;
			cnt_q     <= '0;
		end else if (ctl.upd) begin
			if (ctl.tick) begin
				if (cnt_adv) begin
					cnt_q <= cnt_q + mid_pkg::CNT_W'(1);
				end
			end else begin
				sampled_q <= raw;
				cnt_q     <= cnt_smp;
				stable_q  <= stable_d;
			end
		end
	end

	assign stat.stable_q = stable_q;
	assign stat.stable_d = stable_d;

endmodule

`default_nettype wire

// ===== src/multi_input_debouncer_top.sv =====
// Top level of the multi-input debouncer: handshake, register port, result register.
// Depends on mid_pkg and mid_chan.
`default_nettype none

// Debounces a bank of channels, one settle counter each. A sample item (func 0)
// brings raw_pins; a channel whose level changed restarts its counter, and a channel
// whose counter has reached settle_time takes the sampled level (inverted where its
// normally_open_mask bit is set) as its stable level. A tick item (func 1) advances
// every counter up to one past settle_time. Each item returns stable_levels_out.
// One item is accepted every cycle while no result is held by result_stall; an item
// waits in the input register and its result is then presented from the result
// register. settle_time sits at byte address 0, normally_open_mask at 4.
module multi_input_debouncer_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          sample_valid,
	output logic                         sample_stall,
	input  wire                          func,
	input  wire  [mid_pkg::FIELD_W-1:0]  raw_pins,
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic [mid_pkg::FIELD_W-1:0]  stable_levels_out,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [mid_pkg::ADDR_W-1:0]   paddr,
	input  wire  [mid_pkg::DATA_W-1:0]   pwdata,
	output logic [mid_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	logic [mid_pkg::CNT_W-1:0]   settle_time_q;
	logic [mid_pkg::MASK_W-1:0]  no_mask_q;
	mid_pkg::reg_idx_t           reg_idx;

	logic                        item_valid_s1;
	mid_pkg::func_t              func_s1;
	logic [mid_pkg::FIELD_W-1:0] raw_s1;

	logic                        res_valid_s2;
	logic [mid_pkg::FIELD_W-1:0] res_levels_s2;

	logic                        adv;
	logic                        take;
	mid_pkg::chan_ctl_t          ctl;
	mid_pkg::chan_stat_t         stat [mid_pkg::CHANNELS];
	logic [mid_pkg::CHANNELS-1:0] stable_q_vec;
	logic [mid_pkg::CHANNELS-1:0] stable_d_vec;
	logic [mid_pkg::FIELD_W-1:0]  levels_d;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = mid_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_time_q <= mid_pkg::SETTLE_RESET;
			no_mask_q     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				mid_pkg::REG_SETTLE_TIME: settle_time_q <= pwdata[mid_pkg::CNT_W-1:0];
				mid_pkg::REG_NO_MASK:     no_mask_q     <= pwdata[mid_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			mid_pkg::REG_SETTLE_TIME: prdata = mid_pkg::DATA_W'(settle_time_q);
			mid_pkg::REG_NO_MASK:     prdata = mid_pkg::DATA_W'(no_mask_q);
			default: ;
		endcase
	end

	// advance the input register into the result register unless a result is held
	assign adv          = !res_valid_s2 || !result_stall;
	assign sample_stall = item_valid_s1 && !adv;
	assign take         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take) begin
			item_valid_s1 <= 1'b1;
		end else if (adv) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= mid_pkg::func_t'(func);
			raw_s1  <= raw_pins;
		end
	end

	assign ctl.upd         = item_valid_s1 && adv;
	assign ctl.tick        = func_s1 == mid_pkg::FUNC_TICK;
	assign ctl.settle_time = settle_time_q;

	for (genvar n = 0; n < mid_pkg::CHANNELS; n++) begin : g_chan
		logic raw_bit;
		logic no_bit;
		if (n < mid_pkg::FIELD_W) begin : g_pin
			assign raw_bit = raw_s1[n];
		end else begin : g_nopin
			assign raw_bit = 1'b0;
		end
		if (n < mid_pkg::MASK_W) begin : g_mask
			assign no_bit = no_mask_q[n];
		end else begin : g_nomask
			assign no_bit = 1'b0;
		end
		mid_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.raw    (raw_bit),
			.no_bit (no_bit),
			.stat   (stat[n])
		);
		assign stable_q_vec[n] = stat[n].stable_q;
		assign stable_d_vec[n] = stat[n].stable_d;
	end

	for (genvar f = 0; f < mid_pkg::FIELD_W; f++) begin : g_field
		if (f < mid_pkg::CHANNELS) begin : g_used
			assign levels_d[f] = stable_d_vec[f];
		end else begin : g_unused
			assign levels_d[f] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv) begin
			res_valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			res_levels_s2 <= levels_d;
		end
	end

	assign result_valid      = res_valid_s2;
	assign stable_levels_out = res_levels_s2;

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> item_valid_s1 && res_valid_s2 && result_stall)
		else $error("input stalled with no item blocking it");

	a_upd_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |=> result_valid)
		else $error("processed item produced no result");

	a_tick_keeps_levels: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd && ctl.tick |=> stable_q_vec == $past(stable_q_vec))
		else $error("tick item changed stable levels");

	a_idle_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.upd |=> $stable(stable_q_vec))
		else $error("stable levels changed without an item");
`endif

endmodule

`default_nettype wire

// ===== verif/mid_level_checker.sv =====
// Predicts and checks the stable levels returned by the multi-input debouncer.
// Watches the sample, result and register channels; depends on mid_pkg.
`default_nettype none

module mid_level_checker
	import mid_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                sample_valid,
	input  wire                sample_stall,
	input  wire                func,
	input  wire  [FIELD_W-1:0] raw_pins,
	input  wire                result_valid,
	input  wire                result_stall,
	input  wire  [FIELD_W-1:0] stable_levels_out,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire                pready,
	input  wire  [ADDR_W-1:0]  paddr,
	input  wire  [DATA_W-1:0]  pwdata,
	output int                 errors,
	output int                 pending,
	output int                 checked
);

	logic [CHANNELS-1:0] pin_seen;
	logic [CHANNELS-1:0] level_held;
	logic [CNT_W-1:0]    settle_cnt [CHANNELS];
	logic [CNT_W-1:0]    cfg_settle;
	logic [MASK_W-1:0]   cfg_no_mask;
	logic [FIELD_W-1:0]  levels_due [$];

	task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		errors++;
		$display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
	endtask

	task automatic predict_levels(input logic f, input logic [FIELD_W-1:0] raw,
			output logic [FIELD_W-1:0] levels);
		logic pin;
		logic inv;
		for (int n = 0; n < CHANNELS; n++) begin
			// channels past the field width see zero level and zero mask
			pin = (n < FIELD_W) ? raw[n] : 1'b0;
			inv = (n < MASK_W) ? cfg_no_mask[n] : 1'b0;
			if (func_t'(f) == FUNC_SAMPLE) begin
				if (pin != pin_seen[n]) begin
					pin_seen[n] = pin;
					settle_cnt[n] = '0;
				end
				if (settle_cnt[n] >= cfg_settle)
					level_held[n] = pin_seen[n] ^ inv;
			end else begin
				// advance up to one past the settle time, saturate at all ones
				if (settle_cnt[n] <= cfg_settle && settle_cnt[n] != '1)
					settle_cnt[n] = settle_cnt[n] + 1'b1;
			end
		end
		levels = FIELD_W'(level_held);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [FIELD_W-1:0] want;
		if (!arst_n) begin
			pin_seen = '0;
			level_held = '0;
			for (int n = 0; n < CHANNELS; n++)
				settle_cnt[n] = '0;
			cfg_settle = SETTLE_RESET;
			cfg_no_mask = '0;
			levels_due.delete();
			pending = 0;
		end else begin
			// a result always leaves after its item was taken, so check before predicting
			if (result_valid && !result_stall) begin
				if (levels_due.size() == 0) begin
					flag_mismatch("item with nothing expected", '0, stable_levels_out);
				end else begin
					want = levels_due.pop_front();
					checked++;
					if (want !== stable_levels_out)
						flag_mismatch("stable_levels_out", want, stable_levels_out);
				end
			end
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_SETTLE_TIME: cfg_settle = pwdata[CNT_W-1:0];
					REG_NO_MASK:     cfg_no_mask = pwdata[MASK_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				predict_levels(func, raw_pins, want);
				levels_due.push_back(want);
			end
			pending = levels_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== verif/multi_input_debouncer_top_tb.sv =====
// Stimulus and verdict for the multi-input debouncer.
// Depends on mid_pkg, multi_input_debouncer_top and mid_level_checker.
`default_nettype none

module multi_input_debouncer_top_tb;
	import mid_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	func_t              func = FUNC_SAMPLE;
	logic [FIELD_W-1:0] raw_pins = '0;
	logic               result_stall = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;

	wire                sample_stall;
	wire                result_valid;
	wire  [FIELD_W-1:0] stable_levels_out;
	wire  [DATA_W-1:0]  prdata;
	wire                pready;

	int errors;
	int pending;
	int checked;
	bit idle_on = 1'b0;
	int items_sent = 0;
	int writes_done = 0;

	multi_input_debouncer_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.func              (func),
		.raw_pins          (raw_pins),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.stable_levels_out (stable_levels_out),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	mid_level_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.func              (func),
		.raw_pins          (raw_pins),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.stable_levels_out (stable_levels_out),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.pready            (pready),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.errors            (errors),
		.pending           (pending),
		.checked           (checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("multi_input_debouncer_top_tb failed");
		$finish;
	end

	// result side: random stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 8);
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input func_t f, input logic [FIELD_W-1:0] raw);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		sample_valid <= 1'b1;
		func <= f;
		raw_pins <= raw;
		do @(posedge clk); while (sample_stall);
		items_sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every expected item is back
	task automatic drain;
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] keep;
		keep = (idx == REG_SETTLE_TIME) ? DATA_W'((1 << CNT_W) - 1) : DATA_W'((1 << MASK_W) - 1);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// fill bits above the register with noise
		pwdata <= ($urandom() & ~keep) | (value & keep);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		writes_done++;
	endtask

	initial begin
		logic [FIELD_W-1:0] lvl;
		logic [CNT_W-1:0]   settle;
		logic [MASK_W-1:0]  mask;
		int                 pick;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_on = 1'b1;

		// reset settings: settle time 4, no inverted channels
		send_item(FUNC_SAMPLE, '1);
		repeat (4) send_item(FUNC_TICK, FIELD_W'('h155));
		send_item(FUNC_SAMPLE, '1);
		send_item(FUNC_TICK, '0);
		send_item(FUNC_SAMPLE, '0);
		repeat (6) send_item(FUNC_TICK, '1);
		send_item(FUNC_SAMPLE, '0);
		send_item(FUNC_SAMPLE, FIELD_W'('h200));
		send_item(FUNC_SAMPLE, '0);
		drain();

		// zero settle time, every channel inverted
		write_reg(REG_SETTLE_TIME, '0);
		write_reg(REG_NO_MASK, '1);
		send_item(FUNC_SAMPLE, FIELD_W'('h155));
		send_item(FUNC_SAMPLE, FIELD_W'('h2AA));
		send_item(FUNC_TICK, '0);
		send_item(FUNC_SAMPLE, '0);
		drain();

		// counter holds at all ones when settle time is all ones
		write_reg(REG_SETTLE_TIME, '1);
		write_reg(REG_NO_MASK, DATA_W'($urandom_range(0, 1023)));
		send_item(FUNC_SAMPLE, FIELD_W'('h2AA));
		repeat (257) send_item(FUNC_TICK, FIELD_W'($urandom()));
		send_item(FUNC_SAMPLE, FIELD_W'('h2AA));
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin settle = CNT_W'(1); mask = '0; end
				1: begin settle = CNT_W'(3); mask = '1; end
				2: begin settle = CNT_W'(254); mask = MASK_W'($urandom()); end
				3: begin settle = CNT_W'($urandom_range(0, 6)); mask = MASK_W'($urandom()); end
				default: begin
					settle = CNT_W'($urandom_range(0, 2));
					mask = MASK_W'($urandom());
				end
			endcase
			idle_on = (phase != 4);
			write_reg(REG_SETTLE_TIME, DATA_W'(settle));
			write_reg(REG_NO_MASK, DATA_W'(mask));
			lvl = FIELD_W'($urandom());
			// mostly a held level with ticks, some glitches and level changes
			repeat (70) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					lvl = FIELD_W'($urandom());
					send_item(FUNC_SAMPLE, lvl);
				end else if (pick < 20) begin
					send_item(FUNC_SAMPLE, lvl ^ FIELD_W'($urandom_range(1, 1023)));
				end else if (pick < 55) begin
					send_item(FUNC_TICK, FIELD_W'($urandom()));
				end else begin
					send_item(FUNC_SAMPLE, lvl);
				end
			end
			drain();
		end

		$display("sent %0d items, checked %0d results, made %0d register writes",
			items_sent, checked, writes_done);
		$display("settle times 0, 1, 3, 4, 254, 255 and random ones up to 6; masks clear, full and random");
		if (errors == 0)
			$display("multi_input_debouncer_top_tb passed");
		else
			$display("multi_input_debouncer_top_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
